### sv/lpht_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package lpht_pkg;

  localparam int MAX_SLOTS = 1024;
  localparam int SLOT_W    = $clog2(MAX_SLOTS);
  localparam int CNT_W     = SLOT_W + 1;
  localparam int DAT_W     = 32 + 32 + 16;

  localparam logic [31:0] BLK_EMPTY   = 32'hFFFF_FFFF;
  localparam logic [31:0] BLK_DELETED = 32'hFFFF_FFFE;

  localparam logic [2:0] OP_LOOKUP     = 3'd0;
  localparam logic [2:0] OP_LOOKUP_LOC = 3'd1;
  localparam logic [2:0] OP_INSERT     = 3'd2;
  localparam logic [2:0] OP_REMOVE     = 3'd3;
  localparam logic [2:0] OP_REMOVE_LOC = 3'd4;

  localparam logic [1:0] ST_DONE     = 2'd0;
  localparam logic [1:0] ST_NOTFOUND = 2'd1;
  localparam logic [1:0] ST_FULL     = 2'd2;

  typedef struct packed {
    logic [2:0]  opcode;
    logic [31:0] name_hash_a;
    logic [31:0] name_hash_b;
    logic [31:0] start_hash;
    logic [15:0] locale;
    logic [31:0] block_index;
  } lpht_in_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [9:0]  slot_index;
    logic [10:0] occupied_count;
  } lpht_out_t;

  typedef struct packed {
    logic clear_en;
    logic load_item;
    logic probe_check;
    logic out_load;
  } ctl_cmd_t;

  typedef struct packed {
    logic clear_last;
    logic op_bad;
    logic probe_end;
  } ctl_st_t;

endpackage

`default_nettype wire

### sv/lpht_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module lpht_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

### sv/lpht_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module lpht_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  output logic                   out_valid,
  input  wire logic              out_ready,
  input  wire lpht_pkg::ctl_st_t st,
  output lpht_pkg::ctl_cmd_t     cmd
);
  import lpht_pkg::*;

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_READ  = 3'd2;
  localparam logic [2:0] S_CHECK = 3'd3;
  localparam logic [2:0] S_FIN   = 3'd4;

  logic [2:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r;
    cmd           = '0;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    case (state_r)
      S_CLEAR: begin
        cmd.clear_en = 1'b1;
        if (st.clear_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_item = 1'b1;
          state_nxt     = S_READ;
        end
      end
      S_READ: begin
        // The read data for the current slot arrives in the next cycle.
        state_nxt = st.op_bad ? S_FIN : S_CHECK;
      end
      S_CHECK: begin
        cmd.probe_check = 1'b1;
        state_nxt       = st.probe_end ? S_FIN : S_READ;
      end
      S_FIN: begin
        if (!out_valid_r || out_ready) begin
          cmd.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

  a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CLEAR) |-> !in_ready)
    else $error("input taken during clearing pass");

  a_check_after_read: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CHECK) |-> ($past(state_r) == S_READ))
    else $error("slot checked without a read");

  a_load_keeps_result: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.out_load && out_valid_r) |-> out_ready)
    else $error("pending result overwritten");

endmodule

`default_nettype wire

### sv/lpht_dp.sv
`timescale 1ns / 1ps
`default_nettype none

module lpht_dp (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               cfg_valid,
  input  wire logic [3:0]         cfg_data,
  input  wire lpht_pkg::lpht_in_t in_data,
  input  wire lpht_pkg::ctl_cmd_t cmd,
  output lpht_pkg::ctl_st_t       st,
  output lpht_pkg::lpht_out_t     out_data
);
  import lpht_pkg::*;

  localparam int MAX_LOG2 = SLOT_W;

  logic [3:0]        cfg_r;
  lpht_in_t          item_r;
  logic [SLOT_W-1:0] idx_r;
  logic [SLOT_W-1:0] k_r;
  logic [SLOT_W-1:0] clr_r;
  logic [1:0]        res_status_r;
  logic [SLOT_W-1:0] res_slot_r;
  logic [CNT_W-1:0]  occ_r;
  lpht_out_t         out_r;

  logic [3:0]        lg_eff;
  logic [SLOT_W:0]   mask_wide;
  logic [SLOT_W-1:0] mask;
  logic [31:0]       blk_rdata;
  logic [DAT_W-1:0]  dat_rdata;
  logic              blk_we;
  logic [SLOT_W-1:0] blk_waddr;
  logic [31:0]       blk_wdata;
  logic              dat_we;
  logic              is_ins, is_rem, use_loc;
  logic              occ, empty, match, take, hit, last;

  // Sizes above the store are clamped to the whole store.
  assign lg_eff    = (cfg_r > 4'(MAX_LOG2)) ? 4'(MAX_LOG2) : cfg_r;
  assign mask_wide = ({{SLOT_W{1'b0}}, 1'b1} << lg_eff) - {{SLOT_W{1'b0}}, 1'b1};
  assign mask      = mask_wide[SLOT_W-1:0];

  assign is_ins  = (item_r.opcode == OP_INSERT);
  assign is_rem  = (item_r.opcode == OP_REMOVE) || (item_r.opcode == OP_REMOVE_LOC);
  assign use_loc = (item_r.opcode == OP_LOOKUP_LOC) || (item_r.opcode == OP_REMOVE_LOC);

  assign occ   = (blk_rdata < BLK_DELETED);
  assign empty = (blk_rdata == BLK_EMPTY);
  assign match = occ
              && (dat_rdata[DAT_W-1 -: 32] == item_r.name_hash_a)
              && (dat_rdata[47:16] == item_r.name_hash_b)
              && (!use_loc || (dat_rdata[15:0] == item_r.locale));
  assign take  = is_ins && !occ;
  assign hit   = !is_ins && match;
  assign last  = (k_r == mask);

  assign st.clear_last = (clr_r == {SLOT_W{1'b1}});
  assign st.op_bad     = (item_r.opcode > OP_REMOVE_LOC);
  assign st.probe_end  = take || hit || last || (!is_ins && empty);

  assign blk_we    = cmd.clear_en || (cmd.probe_check && (take || (hit && is_rem)));
  assign blk_waddr = cmd.clear_en ? clr_r : idx_r;
  assign blk_wdata = cmd.clear_en ? BLK_EMPTY : (take ? item_r.block_index : BLK_DELETED);
  assign dat_we    = cmd.probe_check && take;

  lpht_ram #(.WIDTH(32), .DEPTH(MAX_SLOTS)) u_blk_ram (
    .clk   (clk),
    .we    (blk_we),
    .waddr (blk_waddr),
    .wdata (blk_wdata),
    .raddr (idx_r),
    .rdata (blk_rdata)
  );

  lpht_ram #(.WIDTH(DAT_W), .DEPTH(MAX_SLOTS)) u_dat_ram (
    .clk   (clk),
    .we    (dat_we),
    .waddr (idx_r),
    .wdata ({item_r.name_hash_a, item_r.name_hash_b, item_r.locale}),
    .raddr (idx_r),
    .rdata (dat_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= 4'(MAX_LOG2);
      clr_r <= '0;
      occ_r <= '0;
    end else begin
      if (cfg_valid) begin
        cfg_r <= cfg_data;
      end
      if (cmd.clear_en) begin
        clr_r <= clr_r + 1'b1;
      end
      if (cmd.probe_check) begin
        // An insert of a marker block index leaves the slot unoccupied.
        if (take && (item_r.block_index < BLK_DELETED)) begin
          occ_r <= occ_r + 1'b1;
        end else if (hit && is_rem && (occ_r != '0)) begin
          occ_r <= occ_r - 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      item_r       <= in_data;
      idx_r        <= in_data.start_hash[SLOT_W-1:0] & mask;
      k_r          <= '0;
      res_status_r <= ST_NOTFOUND;
      res_slot_r   <= '0;
    end else if (cmd.probe_check) begin
      if (take || hit) begin
        res_status_r <= ST_DONE;
        res_slot_r   <= idx_r;
      end else if (is_ins && last) begin
        res_status_r <= ST_FULL;
      end
      if (!st.probe_end) begin
        idx_r <= (idx_r + 1'b1) & mask;
        k_r   <= k_r + 1'b1;
      end
    end
    if (cmd.out_load) begin
      out_r.status         <= res_status_r;
      out_r.slot_index     <= res_slot_r;
      out_r.occupied_count <= occ_r;
    end
  end

  assign out_data = out_r;

  a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
    occ_r <= CNT_W'(MAX_SLOTS))
    else $error("occupied count above store size");

  a_idx_in_table: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.probe_check |-> ((idx_r & ~mask) == '0))
    else $error("probe outside the table in use");

  a_write_only_on_check: assert property (@(posedge clk) disable iff (!rst_n)
    (blk_we && !cmd.clear_en) |-> (cmd.probe_check && !st.op_bad))
    else $error("slot written outside a probe");

endmodule

`default_nettype wire

### sv/linear_probe_hash_table.sv
`timescale 1ns / 1ps
`default_nettype none

// Open-addressed hash table with linear probing over 1024 slots, of which
// 2^table_size_log2 are in use (sizes above 10 count as 10). After reset the
// block runs a clearing pass that marks every slot empty; in_ready stays low
// until it ends, while configuration writes are taken at any time (cfg_ready
// is always high). Each probe has two steps, one to read the slot memories
// and one to check the registered read data. An item's probes end at the
// slot that decides it, at the latest after a full wrap of the table in use.
// An unknown opcode finishes without checking any slot. One item is worked
// on at a time; the result sits in an output register so the next item can
// be accepted while it waits to be taken.
module linear_probe_hash_table (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                cfg_valid,
  output logic                     cfg_ready,
  input  wire logic [3:0]          cfg_data,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire lpht_pkg::lpht_in_t  in_data,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output lpht_pkg::lpht_out_t      out_data
);
  import lpht_pkg::*;

  ctl_cmd_t cmd;
  ctl_st_t  st;

  assign cfg_ready = 1'b1;

  lpht_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .st        (st),
    .cmd       (cmd)
  );

  lpht_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_data  (cfg_data),
    .in_data   (in_data),
    .cmd       (cmd),
    .st        (st),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

### tb/sv/linear_probe_hash_table_tb.sv
`timescale 1ns / 1ps

module linear_probe_hash_table_tb;
  import lpht_pkg::*;

  localparam int LIMIT_CYCLES = 2_000_000;
  localparam int IDLE_PCT     = 31;

  // Scoreboard: keeps its own copy of the slot store, predicts every result
  // from the accepted item and compares the block's results in order.
  class lpht_scoreboard;
    logic [31:0]      hash_a_mem [MAX_SLOTS];
    logic [31:0]      hash_b_mem [MAX_SLOTS];
    logic [15:0]      locale_mem [MAX_SLOTS];
    logic [31:0]      block_mem  [MAX_SLOTS];
    logic [CNT_W-1:0] occupied;
    logic [3:0]       size_log2;
    lpht_out_t        awaited_results [$];
    int               mismatches;
    int               unexpected;

    function new();
      for (int i = 0; i < MAX_SLOTS; i++) begin
        hash_a_mem[i] = '1;
        hash_b_mem[i] = '1;
        locale_mem[i] = '1;
        block_mem[i]  = BLK_EMPTY;
      end
      occupied   = '0;
      size_log2  = 4'd10;
      mismatches = 0;
      unexpected = 0;
    endfunction

    function void set_size(logic [3:0] v);
      size_log2 = v;
    endfunction

    // Sizes beyond the store are clamped to the whole store.
    function int unsigned slots_in_use();
      if (size_log2 > SLOT_W) return MAX_SLOTS;
      return 1 << size_log2;
    endfunction

    function bit is_occupied(int unsigned idx);
      return block_mem[idx] < BLK_DELETED;
    endfunction

    function int find_entry(logic [31:0] ha, logic [31:0] hb, logic [31:0] start,
                            bit match_loc, logic [15:0] loc);
      int unsigned n;
      int unsigned idx;
      int unsigned k;
      n   = slots_in_use();
      idx = start & (n - 1);
      for (k = 0; k < n; k++) begin
        if (block_mem[idx] == BLK_EMPTY) return -1;
        if (is_occupied(idx) && hash_a_mem[idx] == ha && hash_b_mem[idx] == hb &&
            (!match_loc || locale_mem[idx] == loc))
          return idx;
        idx = (idx + 1) & (n - 1);
      end
      return -1;
    endfunction

    function void apply_op(lpht_in_t it);
      lpht_out_t   r;
      int          hit;
      int unsigned n;
      int unsigned idx;
      int unsigned k;
      r.status     = ST_NOTFOUND;
      r.slot_index = '0;
      case (it.opcode)
        OP_LOOKUP, OP_LOOKUP_LOC, OP_REMOVE, OP_REMOVE_LOC: begin
          hit = find_entry(it.name_hash_a, it.name_hash_b, it.start_hash,
                           it.opcode == OP_LOOKUP_LOC || it.opcode == OP_REMOVE_LOC,
                           it.locale);
          if (hit >= 0) begin
            r.status     = ST_DONE;
            r.slot_index = hit[SLOT_W-1:0];
            if (it.opcode == OP_REMOVE || it.opcode == OP_REMOVE_LOC) begin
              block_mem[hit] = BLK_DELETED;
              if (occupied != 0) occupied = occupied - 1'b1;
            end
          end
        end
        OP_INSERT: begin
          r.status = ST_FULL;
          n        = slots_in_use();
          idx      = it.start_hash & (n - 1);
          for (k = 0; k < n; k++) begin
            if (!is_occupied(idx)) begin
              hash_a_mem[idx] = it.name_hash_a;
              hash_b_mem[idx] = it.name_hash_b;
              locale_mem[idx] = it.locale;
              block_mem[idx]  = it.block_index;
              // A marker block index leaves the slot empty or deleted.
              if (is_occupied(idx)) occupied = occupied + 1'b1;
              r.status     = ST_DONE;
              r.slot_index = idx[SLOT_W-1:0];
              break;
            end
            idx = (idx + 1) & (n - 1);
          end
        end
        default: ;
      endcase
      r.occupied_count = occupied;
      awaited_results.push_back(r);
    endfunction

    function void check_result(lpht_out_t got);
      lpht_out_t want;
      if (awaited_results.size() == 0) begin
        unexpected++;
        $display("unexpected result: status %0d slot %0d count %0d",
                 got.status, got.slot_index, got.occupied_count);
        return;
      end
      want = awaited_results.pop_front();
      if (got.status !== want.status || got.slot_index !== want.slot_index ||
          got.occupied_count !== want.occupied_count) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: status %0d/%0d slot %0d/%0d count %0d/%0d (expected/actual)",
                   want.status, got.status, want.slot_index, got.slot_index,
                   want.occupied_count, got.occupied_count);
      end
    endfunction

    function int pending();
      return awaited_results.size();
    endfunction
  endclass

  typedef struct {
    logic [31:0] ha;
    logic [31:0] hb;
    logic [31:0] start;
    logic [15:0] loc;
  } table_key_t;

  logic       clk;
  logic       rst_n;
  logic       cfg_valid;
  logic       cfg_ready;
  logic [3:0] cfg_data;
  logic       in_valid;
  logic       in_ready;
  lpht_in_t   in_data;
  logic       out_valid;
  logic       out_ready;
  lpht_out_t  out_data;

  lpht_scoreboard sb;
  table_key_t     key_pool [$];
  bit             calm;
  int             cycle_count;

  int phase_sizes [20] = '{0, 1, 2, 3, 4, 2, 15, 1, 3, 10, 4, 5, 0, 6, 11, 2, 3, 7, 1, 12};

  linear_probe_hash_table dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(negedge clk) begin
    out_ready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
  end

  always @(posedge clk) begin
    if (rst_n === 1'b1 && out_valid === 1'b1 && out_ready === 1'b1)
      sb.check_result(out_data);
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < LIMIT_CYCLES) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Regression FAIL");
    $finish;
  end

  function automatic lpht_in_t make_item(logic [2:0] op, logic [31:0] ha, logic [31:0] hb,
                                         logic [31:0] start, logic [15:0] loc,
                                         logic [31:0] blk);
    lpht_in_t it;
    it.opcode      = op;
    it.name_hash_a = ha;
    it.name_hash_b = hb;
    it.start_hash  = start;
    it.locale      = loc;
    it.block_index = blk;
    return it;
  endfunction

  function automatic table_key_t pick_key();
    return key_pool[$urandom_range(0, key_pool.size() - 1)];
  endfunction

  // Mostly operations on keys already inserted, so that chains, hits and
  // removals happen often; the rest is random noise and unknown opcodes.
  function automatic lpht_in_t random_item();
    lpht_in_t    it;
    table_key_t  k;
    int unsigned r;
    it = make_item(3'($urandom_range(0, 4)), $urandom(), $urandom(), $urandom(),
                   16'($urandom_range(0, 65535)), $urandom());
    if ($urandom_range(0, 99) < 10)
      it.block_index = ($urandom_range(0, 1) != 0) ? BLK_EMPTY : BLK_DELETED;
    r = $urandom_range(0, 99);
    if (r < 35) begin
      it.opcode = OP_INSERT;
      if (key_pool.size() != 0 && $urandom_range(0, 99) < 40) begin
        k = pick_key();
        it.name_hash_a = k.ha;
        it.name_hash_b = k.hb;
        it.start_hash  = k.start;
        if ($urandom_range(0, 1) != 0) it.locale = k.loc;
      end else if ($urandom_range(0, 1) != 0) begin
        it.name_hash_a = $urandom_range(0, 3);
        it.name_hash_b = $urandom_range(0, 3);
      end
      k.ha    = it.name_hash_a;
      k.hb    = it.name_hash_b;
      k.start = it.start_hash;
      k.loc   = it.locale;
      key_pool.push_back(k);
      if (key_pool.size() > 64) void'(key_pool.pop_front());
    end else if (r < 75 && key_pool.size() != 0) begin
      k = pick_key();
      it.name_hash_a = k.ha;
      it.name_hash_b = k.hb;
      it.start_hash  = k.start;
      if ($urandom_range(0, 99) >= 20) it.locale = k.loc;
      case ($urandom_range(0, 3))
        0: it.opcode = OP_LOOKUP;
        1: it.opcode = OP_LOOKUP_LOC;
        2: it.opcode = OP_REMOVE;
        default: it.opcode = OP_REMOVE_LOC;
      endcase
    end else if (r >= 92) begin
      it.opcode = OP_REMOVE_LOC + 3'($urandom_range(1, 3));
    end
    return it;
  endfunction

  // Starts just after a rising edge; returns at the edge that took the item.
  task automatic send_item(input lpht_in_t it);
    @(negedge clk);
    while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (in_ready !== 1'b1);
    sb.apply_op(it);
  endtask

  task automatic stop_sending();
    @(negedge clk);
    in_valid <= 1'b0;
  endtask

  task automatic wait_drained();
    while (sb.pending() != 0) @(posedge clk);
  endtask

  task automatic write_size(input logic [3:0] v);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    sb.set_size(v);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    int total_errors;
    int n_items;
    sb        = new();
    calm      = 1'b0;
    rst_n     = 1'b0;
    cfg_valid = 1'b0;
    cfg_data  = '0;
    in_valid  = 1'b0;
    in_data   = '0;
    out_ready = 1'b0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed part at the reset size of 1024 slots.
    send_item(make_item(OP_LOOKUP, '0, '0, '0, '0, '0));
    send_item(make_item(OP_REMOVE, '0, '0, '0, '0, '0));
    send_item(make_item(OP_INSERT, '1, '1, '1, '1, '0));
    // Same hashes, other locale: slot 1023 is taken, so the probe wraps to 0.
    send_item(make_item(OP_INSERT, '1, '1, '1, 16'h0000, 32'hFFFF_FFFD));
    send_item(make_item(OP_LOOKUP, '1, '1, '1, 16'h0000, '0));
    send_item(make_item(OP_LOOKUP_LOC, '1, '1, '1, 16'h0000, '0));
    // Inserts carrying the empty and deleted markers leave their slots free.
    send_item(make_item(OP_INSERT, 32'd1, 32'd2, 32'd5, 16'h1234, BLK_EMPTY));
    send_item(make_item(OP_INSERT, 32'd1, 32'd2, 32'd6, 16'h1234, BLK_DELETED));
    send_item(make_item(OP_INSERT, 32'd1, 32'd2, 32'd5, 16'h1234, 32'd123));
    send_item(make_item(OP_REMOVE_LOC, 32'd1, 32'd2, 32'd5, 16'h4321, '0));
    send_item(make_item(OP_REMOVE_LOC, 32'd1, 32'd2, 32'd5, 16'h1234, '0));
    send_item(make_item(OP_LOOKUP, 32'd1, 32'd2, 32'd5, 16'h1234, '0));
    send_item(make_item(OP_REMOVE, 32'd1, 32'd2, 32'd5, 16'h1234, '0));
    send_item(make_item(OP_INSERT, 32'd1, 32'd2, 32'd5, 16'h1234, 32'd7));
    send_item(make_item(OP_LOOKUP, 32'd1, 32'd3, 32'd5, 16'h1234, '0));
    send_item(make_item(OP_REMOVE, 32'd1, 32'd2, 32'd5, 16'h1234, '0));
    for (int op = OP_REMOVE_LOC + 1; op < 8; op++)
      send_item(make_item(3'(op), $urandom(), $urandom(), $urandom(),
                          16'($urandom_range(0, 65535)), $urandom()));
    stop_sending();
    wait_drained();

    // A single slot, already occupied: the table is full at once.
    write_size(4'd0);
    send_item(make_item(OP_INSERT, 32'd3, 32'd4, '0, 16'h0005, 32'd9));
    send_item(make_item(OP_LOOKUP_LOC, '1, '1, '1, 16'h0000, '0));
    send_item(make_item(OP_REMOVE, '1, '1, 32'd12345, '0, '0));
    send_item(make_item(OP_INSERT, 32'd3, 32'd4, '1, 16'h0005, 32'hFFFF_FFFD));
    send_item(make_item(OP_LOOKUP, 32'd3, 32'd4, '0, 16'h0005, '0));
    stop_sending();
    wait_drained();

    for (int p = 0; p < 20; p++) begin
      calm = (p == 5);
      write_size(4'(phase_sizes[p]));
      if (phase_sizes[p] <= 4)      n_items = 45;
      else if (phase_sizes[p] <= 7) n_items = 30;
      else                          n_items = 20;
      for (int i = 0; i < n_items; i++) begin
        send_item(random_item());
        if ($urandom_range(0, 99) < 3) begin
          stop_sending();
          wait_drained();
        end
      end
      stop_sending();
      wait_drained();
    end
    calm = 1'b0;

    repeat (2 * MAX_SLOTS + 8) @(posedge clk);
    total_errors = sb.mismatches + sb.unexpected + sb.pending();
    if (total_errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

### sim.f
sv/lpht_pkg.sv
sv/lpht_ram.sv
sv/lpht_ctrl.sv
sv/lpht_dp.sv
sv/linear_probe_hash_table.sv
tb/sv/linear_probe_hash_table_tb.sv
